[rtl/tftp_read_receive_engine_assert.svh]
// Assertion macros used by the receive engine RTL.
`ifndef TFTP_READ_RECEIVE_ENGINE_ASSERT_SVH
`define TFTP_READ_RECEIVE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trre assertion failed");

// Next-cycle implication, checked outside reset.
`define TRRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trre assertion failed");

`endif

[rtl/trre_pkg.sv]
`timescale 1ns / 1ps
package trre_pkg;

   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_TIMEOUT = 2'd1;
   localparam logic [1:0] REQ_START   = 2'd2;

   localparam logic [15:0] OP_DATA  = 16'd3;
   localparam logic [15:0] OP_ERROR = 16'd5;
   localparam logic [15:0] OP_OACK  = 16'd6;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RUNNING  = 3'd1;
   localparam logic [2:0] ST_COMPLETE = 3'd2;
   localparam logic [2:0] ST_ILLEGAL  = 3'd3;
   localparam logic [2:0] ST_TIMEOUT  = 3'd4;
   localparam logic [2:0] ST_REMOTE   = 3'd5;

   localparam logic [15:0] DEFAULT_BLOCK = 16'd512;
   localparam logic [3:0]  OPTION_LEN    = 4'd7;
   localparam logic [3:0]  RETRY_RESET   = 4'd10;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  match_pos;
      logic        name_hit;
      logic        in_name;
      logic [15:0] accum;
      logic        digits_ok;
   } opt_type;

   localparam opt_type OPT_CLEAR = '{match_pos: 4'd0, name_hit: 1'b1, in_name: 1'b1,
                                     accum: 16'd0, digits_ok: 1'b1};

   // Characters of the option name "blksize".
   function automatic logic [7:0] option_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = 8'h62;
         3'd1: c = 8'h6C;
         3'd2: c = 8'h6B;
         3'd3: c = 8'h73;
         3'd4: c = 8'h69;
         3'd5: c = 8'h7A;
         3'd6: c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/trre_if.sv]
`timescale 1ns / 1ps
interface trre_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] packet_byte;
   logic       last_byte;
   modport source (output valid, req_type, packet_byte, last_byte, input ready);
   modport sink   (input valid, req_type, packet_byte, last_byte, output ready);
endinterface

interface trre_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [7:0]  write_byte;
   logic        ack_strobe;
   logic [15:0] ack_block;
   logic        rrq_strobe;
   logic [2:0]  status;
   logic [15:0] remote_code;
   modport source (output valid, write_valid, write_byte, ack_strobe, ack_block,
                   rrq_strobe, status, remote_code, input ready);
   modport sink   (input valid, write_valid, write_byte, ack_strobe, ack_block,
                   rrq_strobe, status, remote_code, output ready);
endinterface

interface trre_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] retry_limit;
   modport source (output valid, retry_limit, input ready);
   modport sink   (input valid, retry_limit, output ready);
endinterface

[rtl/trre_in_reg.sv]
`timescale 1ns / 1ps
module trre_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  trre_pkg::req_item_type in_item,
   input  logic                  advance,
   output logic                  held_valid,
   output trre_pkg::req_item_type held_item
);
   import trre_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset; load only on accept.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

[rtl/trre_oack.sv]
`timescale 1ns / 1ps
module trre_oack (
   input  trre_pkg::opt_type opt_cur,
   input  logic [7:0]        data_byte,
   output trre_pkg::opt_type opt_next,
   output logic              pend_set,
   output logic [15:0]       pend_value
);
   import trre_pkg::*;

   logic [19:0] prod;
   logic        is_digit;

   assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
   // accum * 10 + digit as two shifts and two adds
   assign prod = {1'b0, opt_cur.accum, 3'b000} + {3'b000, opt_cur.accum, 1'b0}
               + {16'd0, data_byte[3:0]};

   always_comb begin
      opt_next   = opt_cur;
      pend_set   = 1'b0;
      pend_value = opt_cur.accum;
      if (data_byte != 8'h00) begin
         if (opt_cur.in_name) begin
            if ((opt_cur.match_pos < OPTION_LEN)
                && (data_byte == option_char(opt_cur.match_pos[2:0]))) begin
               opt_next.match_pos = opt_cur.match_pos + 4'd1;
            end else begin
               opt_next.name_hit = 1'b0;
            end
         end else if (opt_cur.digits_ok && is_digit) begin
            opt_next.accum = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
         end else begin
            opt_next.digits_ok = 1'b0;
         end
      end else if (opt_cur.in_name) begin
         opt_next.in_name = 1'b0;
      end else begin
         // close the pair; keep a nonzero blksize value
         if (opt_cur.name_hit && (opt_cur.match_pos == OPTION_LEN)
             && (opt_cur.accum != 16'd0)) begin
            pend_set = 1'b1;
         end
         opt_next = OPT_CLEAR;
      end
   end

endmodule

[rtl/tftp_read_receive_engine.sv]
`timescale 1ns / 1ps
// TFTP read receive engine: takes one word per cycle on req_bus (a received
// packet byte, a receive timeout tick, or a start command) while the result
// side is not stalled, and returns exactly one result word per input word on
// rsp_bus through the input register and then the result register. Sustained
// rate is one word per clock when unstalled; it is set by the combinational
// update of the transfer state between the input and result registers, which
// let a new word enter while a finished result waits. The result carries
// payload bytes of new DATA blocks, ACK and read request send strobes, the
// transfer status and the remote error code. retry_limit is written through
// csr_bus, which is always ready; write it only while idle.
module tftp_read_receive_engine (
   input  logic       clock,
   input  logic       reset,
   trre_req_if.sink   req_bus,
   trre_rsp_if.source rsp_bus,
   trre_csr_if.sink   csr_bus
);
   import trre_pkg::*;
   `include "tftp_read_receive_engine_assert.svh"

   // transfer phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_RUN   = 2'd1;
   localparam logic [1:0] PH_ENDED = 2'd2;

   // ---------------- input register ----------------
   req_item_type req_item;
   req_item_type cur;
   logic         cur_valid;
   logic         advance;
   logic         fire;

   assign req_item = '{req_type: req_bus.req_type, packet_byte: req_bus.packet_byte,
                       last_byte: req_bus.last_byte};

   trre_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .advance   (advance),
      .held_valid(cur_valid),
      .held_item (cur)
   );

   // ---------------- transfer state ----------------
   logic [3:0]  retry_ff;
   logic [1:0]  phase_ff,   phase_in;
   logic [2:0]  status_ff,  status_in;
   logic [15:0] remote_ff,  remote_in;
   logic [15:0] last_ff,    last_in;
   logic [3:0]  touts_ff,   touts_in;
   logic [15:0] bsize_ff,   bsize_in;
   logic [16:0] bytes_ff,   bytes_in;
   logic [15:0] opcode_ff,  opcode_in;
   logic [15:0] word_ff,    word_in;
   logic        fresh_ff,   fresh_in;
   opt_type     opt_ff,     opt_in;
   logic [15:0] pend_ff,    pend_in;
   logic        pvalid_ff,  pvalid_in;

   // ---------------- result register ----------------
   logic        out_v_ff;
   logic        wv_ff,  wv_in;
   logic [7:0]  wb_ff,  wb_in;
   logic        sa_ff,  sa_in;
   logic [15:0] ab_ff,  ab_in;
   logic        sr_ff,  sr_in;

   // Advance the input register when the result register is free or drains.
   assign advance = !out_v_ff || rsp_bus.ready;
   assign fire    = cur_valid && advance;

   // csr writes are taken at once
   logic csr_take;

   assign csr_bus.ready = 1'b1;
   assign csr_take      = csr_bus.valid && csr_bus.ready;

   // OACK option parser on the current byte
   opt_type     opt_nx;
   logic        pend_set;
   logic [15:0] pend_value;

   trre_oack u_oack (
      .opt_cur   (opt_ff),
      .data_byte (cur.packet_byte),
      .opt_next  (opt_nx),
      .pend_set  (pend_set),
      .pend_value(pend_value)
   );

   logic [16:0] limit;
   logic [3:0]  touts_inc;

   assign limit     = {1'b0, bsize_ff} + 17'd4;
   assign touts_inc = (touts_ff < 4'd15) ? touts_ff + 4'd1 : touts_ff;

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      remote_in = remote_ff;
      last_in   = last_ff;
      touts_in  = touts_ff;
      bsize_in  = bsize_ff;
      bytes_in  = bytes_ff;
      opcode_in = opcode_ff;
      word_in   = word_ff;
      fresh_in  = fresh_ff;
      opt_in    = opt_ff;
      pend_in   = pend_ff;
      pvalid_in = pvalid_ff;
      wv_in     = 1'b0;
      wb_in     = 8'd0;
      sa_in     = 1'b0;
      ab_in     = 16'd0;
      sr_in     = 1'b0;

      if (fire) begin
         priority if (cur.req_type == REQ_START) begin
            // restart from any phase and ask for the read request
            last_in   = 16'd0;
            touts_in  = 4'd0;
            bsize_in  = DEFAULT_BLOCK;
            remote_in = 16'd0;
            bytes_in  = 17'd0;
            opcode_in = 16'd0;
            word_in   = 16'd0;
            fresh_in  = 1'b0;
            pend_in   = 16'd0;
            pvalid_in = 1'b0;
            opt_in    = OPT_CLEAR;
            phase_in  = PH_RUN;
            status_in = ST_RUNNING;
            sr_in     = 1'b1;
         end else if ((cur.req_type == REQ_TIMEOUT) && (phase_ff == PH_RUN)) begin
            // drop the partial packet, resend request or last ACK
            bytes_in  = 17'd0;
            opcode_in = 16'd0;
            word_in   = 16'd0;
            fresh_in  = 1'b0;
            pend_in   = 16'd0;
            pvalid_in = 1'b0;
            opt_in    = OPT_CLEAR;
            if (last_ff == 16'd0) begin
               sr_in = 1'b1;
            end else begin
               sa_in = 1'b1;
               ab_in = last_ff;
            end
            touts_in = touts_inc;
            if (touts_inc >= retry_ff) begin
               phase_in  = PH_ENDED;
               status_in = ST_TIMEOUT;
            end
         end else if ((cur.req_type == REQ_BYTE) && (phase_ff == PH_RUN)) begin
            // bytes past block size plus four are dropped
            if (bytes_ff < limit) begin
               if (bytes_ff == 17'd0) begin
                  opcode_in = {cur.packet_byte, 8'h00};
               end else if (bytes_ff == 17'd1) begin
                  opcode_in = {opcode_ff[15:8], cur.packet_byte};
               end else begin
                  if (bytes_ff <= 17'd3) begin
                     word_in = {word_ff[7:0], cur.packet_byte};
                  end
                  if ((bytes_ff == 17'd3) && (opcode_ff == OP_DATA)) begin
                     fresh_in = (word_in != last_ff);
                  end
                  if ((bytes_ff >= 17'd4) && (opcode_ff == OP_DATA) && fresh_ff) begin
                     wv_in = 1'b1;
                     wb_in = cur.packet_byte;
                  end
                  if (opcode_ff == OP_OACK) begin
                     opt_in = opt_nx;
                     if (pend_set) begin
                        pend_in   = pend_value;
                        pvalid_in = 1'b1;
                     end
                  end
               end
               bytes_in = bytes_ff + 17'd1;
            end
            if (cur.last_byte) begin
               // close the packet on its marked last byte
               if (bytes_in < 17'd2) begin
                  phase_in  = PH_ENDED;
                  status_in = ST_ILLEGAL;
               end else if (opcode_in == OP_DATA) begin
                  if (bytes_in < 17'd4) begin
                     phase_in  = PH_ENDED;
                     status_in = ST_ILLEGAL;
                  end else begin
                     touts_in = 4'd0;
                     sa_in    = 1'b1;
                     ab_in    = word_in;
                     if (fresh_in) begin
                        last_in = word_in;
                        if (bytes_in < limit) begin
                           phase_in  = PH_ENDED;
                           status_in = ST_COMPLETE;
                        end
                     end
                  end
               end else if (opcode_in == OP_ERROR) begin
                  if (bytes_in < 17'd4) begin
                     phase_in  = PH_ENDED;
                     status_in = ST_ILLEGAL;
                  end else begin
                     remote_in = word_in;
                     phase_in  = PH_ENDED;
                     status_in = ST_REMOTE;
                  end
               end else if (opcode_in == OP_OACK) begin
                  touts_in = 4'd0;
                  if (pvalid_in) begin
                     bsize_in = pend_in;
                  end
                  sa_in = 1'b1;
                  ab_in = 16'd0;
               end else begin
                  phase_in  = PH_ENDED;
                  status_in = ST_ILLEGAL;
               end
               bytes_in  = 17'd0;
               opcode_in = 16'd0;
               word_in   = 16'd0;
               fresh_in  = 1'b0;
               pend_in   = 16'd0;
               pvalid_in = 1'b0;
               opt_in    = OPT_CLEAR;
            end
         end else begin
            // idle or ended phase, or an unused request code: no effect
            phase_in = phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff  <= RETRY_RESET;
         phase_ff  <= PH_IDLE;
         status_ff <= ST_IDLE;
         remote_ff <= 16'd0;
         last_ff   <= 16'd0;
         touts_ff  <= 4'd0;
         bsize_ff  <= DEFAULT_BLOCK;
         bytes_ff  <= 17'd0;
         opcode_ff <= 16'd0;
         word_ff   <= 16'd0;
         fresh_ff  <= 1'b0;
         opt_ff    <= OPT_CLEAR;
         pend_ff   <= 16'd0;
         pvalid_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (csr_take) begin
            retry_ff <= csr_bus.retry_limit;
         end
         phase_ff  <= phase_in;
         status_ff <= status_in;
         remote_ff <= remote_in;
         last_ff   <= last_in;
         touts_ff  <= touts_in;
         bsize_ff  <= bsize_in;
         bytes_ff  <= bytes_in;
         opcode_ff <= opcode_in;
         word_ff   <= word_in;
         fresh_ff  <= fresh_in;
         opt_ff    <= opt_in;
         pend_ff   <= pend_in;
         pvalid_ff <= pvalid_in;
         // hold the result until taken, refill on each step
         if (advance) begin
            out_v_ff <= cur_valid;
         end
      end
   end

   // Result payload: load with each step; status and code follow the step.
   logic [2:0]  rstat_ff;
   logic [15:0] rcode_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         wv_ff    <= wv_in;
         wb_ff    <= wb_in;
         sa_ff    <= sa_in;
         ab_ff    <= ab_in;
         sr_ff    <= sr_in;
         rstat_ff <= status_in;
         rcode_ff <= remote_in;
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.write_valid  = wv_ff;
   assign rsp_bus.write_byte   = wb_ff;
   assign rsp_bus.ack_strobe   = sa_ff;
   assign rsp_bus.ack_block    = ab_ff;
   assign rsp_bus.rrq_strobe   = sr_ff;
   assign rsp_bus.status       = rstat_ff;
   assign rsp_bus.remote_code  = rcode_ff;

   // ---------------- checks ----------------
   logic start_fire;
   logic run_seen;

   assign start_fire = fire && (cur.req_type == REQ_START);
   assign run_seen   = (rstat_ff == ST_RUNNING) && (phase_ff == PH_RUN);

   `TRRE_ASSERT_NOW(a_write_no_request, clock, reset, out_v_ff && wv_ff, !sr_ff)
   `TRRE_ASSERT_NEXT(a_start_runs, clock, reset, start_fire, run_seen)
   `TRRE_ASSERT_NEXT(a_csr_write, clock, reset, csr_take, retry_ff == $past(csr_bus.retry_limit))

endmodule
